>>> design/pfss_pkg.sv
`default_nettype none

package pfss_pkg;

  // Field widths and default table size.
  localparam int NUM_W          = 16;
  localparam int TABLE_SIZE_DEF = 65536;
  localparam int MAX_RESULTS    = 15;
  localparam int CNT_W          = 4;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_PCHK,
    S_PTEST,
    S_MRD,
    S_MWR,
    S_IDLE,
    S_LOOK,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic prime_init;
    logic prime_rd;
    logic prime_next;
    logic mark_start;
    logic mark_rd;
    logic mark_wr;
    logic load;
    logic look;
    logic emit_rd;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic isq_end;
    logic j_end;
    logic spf_zero;
    logic num_bad;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

>>> design/pfss_dpath.sv
`default_nettype none

module pfss_dpath #(
  parameter int TABLE_SIZE = pfss_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pfss_pkg::cmd_t              cmd,
  output pfss_pkg::sts_t                   sts,
  input  wire logic [pfss_pkg::NUM_W-1:0]  number,
  output logic      [pfss_pkg::NUM_W-1:0]  prime_factor,
  output logic                             last
);

  // Only numbers below 2^16 are ever looked up, so the table stops there.
  localparam int DEPTH = (TABLE_SIZE < 65536) ? TABLE_SIZE : 65536;
  localparam int AW    = $clog2(DEPTH);
  localparam int JW    = AW + 2;
  localparam int NW    = pfss_pkg::NUM_W;
  localparam int WW    = 2 * NW;

  // Each entry holds the smallest prime factor and the matching quotient.
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_data;

  logic [AW-1:0] cnt;
  logic [JW-1:0] i;
  logic [JW-1:0] isq;
  logic [JW-1:0] j;
  logic [NW-1:0] q;
  logic [NW-1:0] r;
  logic [pfss_pkg::CNT_W-1:0] k;

  logic [NW-1:0] spf;
  logic [NW-1:0] quo;
  logic [NW-1:0] fac_next;
  logic [NW-1:0] quo_next;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_word;
  logic [WW-1:0] clr_word;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign spf = rd_data[WW-1:NW];
  assign quo = rd_data[NW-1:0];

  // Clearing pass: even numbers from 4 up get factor 2, all else is zero.
  always_comb begin
    if (!cnt[0] && cnt >= AW'(4)) begin
      clr_word = {NW'(2), NW'(cnt >> 1)};
    end else begin
      clr_word = '0;
    end
  end

  // Write port: clearing pass or a sieve mark on an unmarked entry.
  assign wr_en   = cmd.clear_wr || (cmd.mark_wr && sts.spf_zero);
  assign wr_addr = cmd.clear_wr ? cnt : j[AW-1:0];
  assign wr_word = cmd.clear_wr ? clr_word : {NW'(i), q};

  // Read port address selection.
  assign rd_en = cmd.prime_rd || cmd.mark_rd || cmd.load || cmd.emit_rd;
  always_comb begin
    if (cmd.prime_rd) begin
      rd_addr = i[AW-1:0];
    end else if (cmd.mark_rd) begin
      rd_addr = j[AW-1:0];
    end else if (cmd.load) begin
      rd_addr = number[AW-1:0];
    end else begin
      rd_addr = r[AW-1:0];
    end
  end

  // Factor table memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // A zero entry marks a prime: the factor is the number itself.
  assign fac_next = sts.spf_zero ? r : spf;
  assign quo_next = sts.spf_zero ? NW'(1) : quo;

  // Clearing pass address counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clear_wr) begin
      cnt <= cnt + AW'(1);
    end
  end

  // Sieve registers: the odd prime, its square, the marked index and quotient.
  always_ff @(posedge clk) begin
    if (cmd.prime_init) begin
      i   <= JW'(3);
      isq <= JW'(9);
    end else if (cmd.prime_next) begin
      i   <= i + JW'(2);
      isq <= isq + (i << 2) + JW'(4);
    end
    if (cmd.mark_start) begin
      j <= isq;
      q <= NW'(i);
    end else if (cmd.mark_wr) begin
      j <= j + (i << 1);
      q <= q + NW'(2);
    end
  end

  // Factorization registers and the result held for the output.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= number;
      k <= '0;
      if (sts.num_bad) begin
        prime_factor <= '0;
        last         <= 1'b1;
      end
    end else if (cmd.look) begin
      prime_factor <= fac_next;
      last         <= (quo_next <= NW'(1)) ||
                      (k == pfss_pkg::CNT_W'(pfss_pkg::MAX_RESULTS - 1));
      r            <= quo_next;
      k            <= k + pfss_pkg::CNT_W'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.clear_done = (cnt == AW'(DEPTH - 1));
    sts.isq_end    = (isq >= JW'(DEPTH));
    sts.j_end      = (j >= JW'(DEPTH));
    sts.spf_zero   = (spf == '0);
    sts.num_bad    = (number <= NW'(1)) || (32'(number) >= 32'(TABLE_SIZE));
    sts.last       = last;
  end

endmodule

`default_nettype wire

>>> design/pfss_ctrl.sv
`default_nettype none

module pfss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  output logic                res_valid,
  input  wire logic           res_ready,
  input  wire pfss_pkg::sts_t sts,
  output pfss_pkg::cmd_t      cmd
);

  pfss_pkg::state_t state;
  pfss_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfss_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    case (state)
      pfss_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) begin
          cmd.prime_init = 1'b1;
          state_next     = pfss_pkg::S_PCHK;
        end
      end
      pfss_pkg::S_PCHK: begin
        if (sts.isq_end) begin
          state_next = pfss_pkg::S_IDLE;
        end else begin
          cmd.prime_rd = 1'b1;
          state_next   = pfss_pkg::S_PTEST;
        end
      end
      pfss_pkg::S_PTEST: begin
        // A marked entry is composite and is skipped.
        if (sts.spf_zero) begin
          cmd.mark_start = 1'b1;
          state_next     = pfss_pkg::S_MRD;
        end else begin
          cmd.prime_next = 1'b1;
          state_next     = pfss_pkg::S_PCHK;
        end
      end
      pfss_pkg::S_MRD: begin
        if (sts.j_end) begin
          cmd.prime_next = 1'b1;
          state_next     = pfss_pkg::S_PCHK;
        end else begin
          cmd.mark_rd = 1'b1;
          state_next  = pfss_pkg::S_MWR;
        end
      end
      pfss_pkg::S_MWR: begin
        cmd.mark_wr = 1'b1;
        state_next  = pfss_pkg::S_MRD;
      end
      pfss_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.num_bad ? pfss_pkg::S_EMIT : pfss_pkg::S_LOOK;
        end
      end
      pfss_pkg::S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = pfss_pkg::S_EMIT;
      end
      pfss_pkg::S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (sts.last) begin
            state_next = pfss_pkg::S_IDLE;
          end else begin
            cmd.emit_rd = 1'b1;
            state_next  = pfss_pkg::S_LOOK;
          end
        end
      end
      default: begin
        state_next = pfss_pkg::S_CLEAR;
      end
    endcase
  end

  // A request and a result are never offered in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(req_ready && res_valid))
    else $error("request and result offered together");

  // An accepted request goes straight to a lookup or a direct result.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == pfss_pkg::S_LOOK || state == pfss_pkg::S_EMIT)
    else $error("accepted request did not start a run");

  // After the final result the block is ready for the next request.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && sts.last |=> req_ready)
    else $error("block not ready after final result");

  // Every lookup is followed by a result.
  assert property (@(posedge clk) disable iff (rst)
    state == pfss_pkg::S_LOOK |=> res_valid)
    else $error("lookup without result");

endmodule

`default_nettype wire

>>> design/prime_factorizer_spf_sieve.sv
// Results: an input of 0, 1 or one at or above TABLE_SIZE gives its single result in the cycle
// after acceptance; otherwise each factor is read from the table, then registered in S_LOOK
// and offered in S_EMIT. The next table read starts only when a factor is taken, and a new
// request is accepted only after the last factor of the previous one is taken.
// Reset: synchronous; a clearing pass over min(TABLE_SIZE, 65536) entries and the odd-only sieve
// run before the first request is accepted.
`default_nettype none

module prime_factorizer_spf_sieve #(
  parameter int TABLE_SIZE = pfss_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [pfss_pkg::NUM_W-1:0]  number,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic      [pfss_pkg::NUM_W-1:0]  prime_factor,
  output logic                             last
);

  pfss_pkg::cmd_t cmd;
  pfss_pkg::sts_t sts;

  // Sequencer for the sieve build and the factorization runs.
  pfss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Factor table, sieve counters and result registers.
  pfss_dpath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .number       (number),
    .prime_factor (prime_factor),
    .last         (last)
  );

endmodule

`default_nettype wire

>>> verif/tb_prime_factorizer_spf_sieve.sv
module tb_prime_factorizer_spf_sieve;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W           = pfss_pkg::NUM_W;
  localparam int TBL_SIZE    = pfss_pkg::TABLE_SIZE_DEF;
  localparam int RUN_CAP     = pfss_pkg::MAX_RESULTS;
  localparam int RANDOM_REQS = 157;

  // One prime factor as it leaves the block.
  typedef struct packed {
    logic [W-1:0] prime_factor;
    logic         last;
  } factor_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         req_valid = 1'b0;
  logic         req_ready;
  logic [W-1:0] number = '0;
  logic         res_valid;
  logic         res_ready = 1'b0;
  logic [W-1:0] prime_factor;
  logic         last;

  // Smallest-prime-factor table of our own; 0 marks a prime.
  logic [W-1:0] spf_table [TBL_SIZE];
  logic [W-1:0] pending_numbers [$];
  factor_t      expected_factors [$];

  int err_count       = 0;
  int reqs_total      = 0;
  int reqs_sent       = 0;
  int factors_checked = 0;
  int longest_run     = 0;
  int req_gap         = 0;
  int res_gap         = 0;
  bit req_quiet       = 1'b0;
  bit res_quiet       = 1'b0;

  prime_factorizer_spf_sieve #(
    .TABLE_SIZE(TBL_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .number(number),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .prime_factor(prime_factor),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Odd-only sieve; even numbers from 4 up get 2, and an entry keeps the first prime.
  function automatic void build_spf_table();
    int i;
    int j;
    for (j = 0; j < TBL_SIZE; j++) spf_table[j] = '0;
    for (j = 4; j < TBL_SIZE; j += 2) spf_table[j] = W'(2);
    for (i = 3; i * i < TBL_SIZE; i += 2) begin
      if (spf_table[i] != 0) continue;
      for (j = i * i; j < TBL_SIZE; j += 2 * i) begin
        if (spf_table[j] == 0) spf_table[j] = W'(i);
      end
    end
  endfunction

  // Append one number to the request queue.
  function automatic void add_number(logic [W-1:0] n);
    pending_numbers = {pending_numbers, n};
  endfunction

  // Queue the ascending prime factors of one accepted request, or a single zero for 0, 1 or out-of-table numbers.
  function automatic void predict_factors(logic [W-1:0] n);
    int      r;
    int      f;
    int      k;
    factor_t item;
    r = n;
    k = 0;
    if (r <= 1 || r >= TBL_SIZE) begin
      item.prime_factor = '0;
      item.last         = 1'b1;
      expected_factors = {expected_factors, item};
      k = 1;
    end else begin
      while (r > 1 && k < RUN_CAP) begin
        f = spf_table[r];
        if (f == 0) f = r;
        r = r / f;
        item.prime_factor = W'(f);
        item.last         = (r <= 1) || (k == RUN_CAP - 1);
        expected_factors = {expected_factors, item};
        k++;
      end
    end
    if (k > longest_run) longest_run = k;
  endfunction

  // Random numbers, weighted toward ones with many small factors.
  function automatic logic [W-1:0] random_number();
    int small_primes [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
    int v;
    int p;
    int n;
    v = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4, 5, 6, 7: begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          p = small_primes[$urandom_range(0, 9)];
          if (v * p < 65536) v = v * p;
        end
        // Sometimes finish with a random, possibly large cofactor.
        if ($urandom_range(0, 2) == 0) v = v * $urandom_range(1, 65535 / v);
      end
      8: begin
        v = 1 << $urandom_range(0, 15);
        v = v * $urandom_range(1, 65535 / v);
      end
      default: v = $urandom_range(0, 15);
    endcase
    return W'(v);
  endfunction

  // Request driver: holds each number until accepted, then may idle before the next one, except in quiet stretches.
  always @(posedge clk) begin : drive_proc
    bit busy;
    if (rst) begin
      req_valid <= 1'b0;
      req_gap = 0;
    end else begin
      busy = req_valid;
      if (req_valid && req_ready) begin
        predict_factors(number);
        reqs_sent++;
        busy = 1'b0;
        if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
        req_gap = req_quiet ? 0 : $urandom_range(0, 4);
      end
      if (!busy) begin
        if (req_gap == 0 && pending_numbers.size() > 0) begin
          number    <= pending_numbers.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
          if (req_gap > 0) req_gap--;
        end
      end
    end
  end

  // Result monitor: compares each factor with the oldest one predicted.
  always @(posedge clk) begin : check_proc
    factor_t want;
    if (rst) begin
      res_ready <= 1'b0;
      res_gap = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_factors.size() == 0) begin
          $error("unexpected result: prime_factor %0d last %0b", prime_factor, last);
          err_count++;
        end else begin
          want = expected_factors.pop_front();
          factors_checked++;
          if (prime_factor !== want.prime_factor) begin
            $error("prime_factor: expected %0d, actual %0d", want.prime_factor, prime_factor);
            err_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            err_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) res_quiet = !res_quiet;
        res_gap = res_quiet ? 0 : $urandom_range(0, 4);
      end
      if (res_gap > 0) begin
        res_ready <= 1'b0;
        res_gap--;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin
    build_spf_table();

    // Directed: zero and one, small primes, sieve squares, numbers marked by two
    // primes, the longest runs, the largest prime and alternating bit patterns.
    add_number(16'd0);
    add_number(16'd1);
    add_number(16'd2);
    add_number(16'd3);
    add_number(16'd4);
    add_number(16'd9);
    add_number(16'd15);
    add_number(16'd45);
    add_number(16'd25);
    add_number(16'd49);
    add_number(16'hFFFF);
    add_number(16'hFFFE);
    add_number(16'h8000);
    add_number(16'hC000);
    add_number(16'd65521);
    add_number(16'd63001);
    add_number(16'd59049);
    add_number(16'd65025);
    add_number(16'd30030);
    add_number(16'd16383);
    add_number(16'd255);
    add_number(16'hAAAA);
    add_number(16'h5555);

    repeat (RANDOM_REQS) add_number(random_number());
    reqs_total = pending_numbers.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The table build takes many cycles before the first request goes through.
    while (reqs_sent < reqs_total) @(posedge clk);
    while (expected_factors.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Factorized %0d requests: edge values, smooth numbers, primes and random words.",
             reqs_sent);
    $display("Compared %0d prime factors; the longest run had %0d factors.",
             factors_checked, longest_run);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard limit, well past the table build plus the slowest request stream.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
